// ===== rtl/sha1_hash_engine_top_defines.svh =====
// Assertion helpers for the engine's RTL, included by the controller file.
`ifndef SHA1_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA1_HASH_ENGINE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHA1_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1 check failed");

// Consequent must hold in the cycle after the antecedent.
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1 check failed");

`endif

// ===== rtl/sha1_pkg.sv =====
`default_nettype none
package sha1_pkg;

    localparam int unsigned NUM_WORDS   = 5;
    localparam int unsigned WINDOW_LEN  = 16;

    localparam logic [6:0] LAST_ROUND   = 7'd79;
    localparam logic [5:0] FILL_LAST    = 6'd63;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [2:0] LEN_LAST     = 3'd7;
    localparam logic [2:0] LAST_WORD    = 3'd4;
    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [63:0] BYTE_BITS   = 64'd8;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMP,
        S_FOLD,
        S_PAD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN,
        PH_DONE
    } t_pad_phase;

    typedef enum logic [1:0] {
        BYTE_DATA,
        BYTE_MARK,
        BYTE_ZERO,
        BYTE_LEN
    } t_byte_src;

    typedef struct packed {
        logic       absorb;
        t_byte_src  src;
        logic       add_len;
        logic       load;
        logic       round;
        logic       fold;
        logic       reset_msg;
        logic [6:0] round_idx;
        logic [2:0] len_idx;
        logic [2:0] word_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== rtl/sha1_datapath.sv =====
`default_nettype none
module sha1_datapath
    import sha1_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    input  wire logic [7:0] i_data_byte,
    output t_dp_status      o_status,
    output logic [31:0]     o_digest_word
);

    logic [31:0] r_chain [NUM_WORDS];
    logic [31:0] n_chain [NUM_WORDS];
    logic [31:0] r_vars  [NUM_WORDS];
    logic [31:0] n_vars  [NUM_WORDS];
    logic [31:0] r_w     [WINDOW_LEN];
    logic [31:0] n_w     [WINDOW_LEN];
    logic [5:0]  r_fill;
    logic [5:0]  n_fill;
    logic [63:0] r_bitlen;
    logic [63:0] n_bitlen;

    logic [7:0]  byte_val;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] sched_x;
    logic [31:0] sched_new;
    logic [31:0] round_sum;
    logic [5:0]  len_base;

    assign len_base = {LEN_LAST - i_cmd.len_idx, 3'b000};

    always_comb begin
        case (i_cmd.src)
            BYTE_DATA: byte_val = i_data_byte;
            BYTE_MARK: byte_val = PAD_MARK;
            BYTE_ZERO: byte_val = 8'h00;
            BYTE_LEN:  byte_val = r_bitlen[len_base +: 8];
            default:   byte_val = 8'h00;
        endcase
    end

    // Round function and constant follow the 20-round groups.
    always_comb begin
        if (i_cmd.round_idx < 7'd20) begin
            f_val = (r_vars[1] & r_vars[2]) | (~r_vars[1] & r_vars[3]);
            k_val = K0;
        end else if (i_cmd.round_idx < 7'd40) begin
            f_val = r_vars[1] ^ r_vars[2] ^ r_vars[3];
            k_val = K1;
        end else if (i_cmd.round_idx < 7'd60) begin
            f_val = (r_vars[1] & r_vars[2]) | (r_vars[1] & r_vars[3])
                  | (r_vars[2] & r_vars[3]);
            k_val = K2;
        end else begin
            f_val = r_vars[1] ^ r_vars[2] ^ r_vars[3];
            k_val = K3;
        end
    end

    // The window always holds W[t] in slot 0, so the word sixteen rounds
    // ahead is formed every round and shifted in at the top.
    assign sched_x   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign sched_new = {sched_x[30:0], sched_x[31]};
    assign round_sum = {r_vars[0][26:0], r_vars[0][31:27]} + f_val + r_vars[4]
                     + k_val + r_w[0];

    always_comb begin
        n_w      = r_w;
        n_vars   = r_vars;
        n_chain  = r_chain;
        n_fill   = r_fill;
        n_bitlen = r_bitlen;

        if (i_cmd.absorb) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                n_w[i] = {r_w[i][23:0], r_w[i+1][31:24]};
            end
            n_w[WINDOW_LEN-1] = {r_w[WINDOW_LEN-1][23:0], byte_val};
            n_fill = r_fill + 6'd1;
        end else if (i_cmd.round) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                n_w[i] = r_w[i+1];
            end
            n_w[WINDOW_LEN-1] = sched_new;
        end

        if (i_cmd.add_len) begin
            n_bitlen = r_bitlen + BYTE_BITS;
        end

        if (i_cmd.load) begin
            n_vars = r_chain;
        end else if (i_cmd.round) begin
            n_vars[0] = round_sum;
            n_vars[1] = r_vars[0];
            n_vars[2] = {r_vars[1][1:0], r_vars[1][31:2]};
            n_vars[3] = r_vars[2];
            n_vars[4] = r_vars[3];
        end

        if (i_cmd.fold) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                n_chain[i] = r_chain[i] + r_vars[i];
            end
        end

        if (i_cmd.reset_msg) begin
            n_chain  = '{IV0, IV1, IV2, IV3, IV4};
            n_fill   = '0;
            n_bitlen = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain  <= '{IV0, IV1, IV2, IV3, IV4};
            r_fill   <= '0;
            r_bitlen <= '0;
        end else begin
            r_chain  <= n_chain;
            r_fill   <= n_fill;
            r_bitlen <= n_bitlen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w    <= n_w;
        r_vars <= n_vars;
    end

    assign o_status.fill = r_fill;
    assign o_digest_word = r_chain[i_cmd.word_idx];

endmodule
`default_nettype wire

// ===== rtl/sha1_ctrl.sv =====
`default_nettype none
`include "sha1_hash_engine_top_defines.svh"
module sha1_ctrl
    import sha1_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_has_byte,
    input  wire logic       i_end_of_message,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic [2:0]      o_word_index,
    output logic            o_last_word
);

    t_state     r_state, n_state;
    t_pad_phase r_phase, n_phase;
    logic [6:0] r_round, n_round;
    logic [2:0] r_lidx, n_lidx;
    logic [2:0] r_word, n_word;
    logic       r_fin, n_fin;

    logic in_fire;
    logic out_fire;
    logic full;

    logic comp_last;
    logic comp_start;
    logic pad_done;
    logic digest_end;
    logic back_idle;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;
    assign full     = (i_status.fill == FILL_LAST);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_round = r_round;
        n_lidx  = r_lidx;
        n_word  = r_word;
        n_fin   = r_fin;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_fin = i_end_of_message;
                    if (i_has_byte && full) begin
                        n_state = S_COMP;
                        n_round = '0;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_COMP: begin
                n_round = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_phase == PH_DONE) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                case (r_phase)
                    PH_MARK: n_phase = PH_ZERO;
                    PH_ZERO: begin
                        // At offset 56 the first length byte goes in at once.
                        if (i_status.fill == LEN_POS) begin
                            n_phase = PH_LEN;
                            n_lidx  = r_lidx + 3'd1;
                        end
                    end
                    PH_LEN: begin
                        n_lidx = r_lidx + 3'd1;
                        if (r_lidx == LEN_LAST) begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
                if (full) begin
                    n_state = S_COMP;
                    n_round = '0;
                end
            end
            S_OUT: begin
                if (out_fire) begin
                    n_word = r_word + 3'd1;
                    if (r_word == LAST_WORD) begin
                        n_state = S_IDLE;
                        n_word  = '0;
                        n_fin   = 1'b0;
                        n_phase = PH_MARK;
                        n_lidx  = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.src       = BYTE_DATA;
        o_cmd.round_idx = r_round;
        o_cmd.len_idx   = r_lidx;
        o_cmd.word_idx  = r_word;
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.absorb  = in_fire && i_has_byte;
                o_cmd.add_len = in_fire && i_has_byte;
                o_cmd.load    = in_fire && i_has_byte && full;
            end
            S_COMP: o_cmd.round = 1'b1;
            S_FOLD: o_cmd.fold = 1'b1;
            S_PAD: begin
                o_cmd.absorb = 1'b1;
                o_cmd.load   = full;
                case (r_phase)
                    PH_MARK: o_cmd.src = BYTE_MARK;
                    PH_ZERO: o_cmd.src = (i_status.fill == LEN_POS) ? BYTE_LEN : BYTE_ZERO;
                    PH_LEN:  o_cmd.src = BYTE_LEN;
                    default: o_cmd.src = BYTE_ZERO;
                endcase
            end
            S_OUT: begin
                o_out_valid     = 1'b1;
                o_cmd.reset_msg = out_fire && (r_word == LAST_WORD);
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_MARK;
            r_round <= '0;
            r_lidx  <= '0;
            r_word  <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_round <= n_round;
            r_lidx  <= n_lidx;
            r_word  <= n_word;
            r_fin   <= n_fin;
        end
    end

    assign o_word_index = r_word;
    assign o_last_word  = (r_word == LAST_WORD);

    assign comp_last  = (r_state == S_COMP) && (r_round == LAST_ROUND);
    assign comp_start = (r_state == S_COMP) && (r_round == 7'd0);
    assign pad_done   = (r_phase == PH_DONE) && r_fin;
    assign digest_end = out_fire && (r_word == LAST_WORD);
    assign back_idle  = (r_state == S_IDLE) && (r_word == 3'd0) && (i_status.fill == 6'd0);

    `SHA1_ASSERT_NEXT(a_rounds_end, i_clk, i_rst_n, comp_last, r_state == S_FOLD)
    `SHA1_ASSERT_NEXT(a_full_starts_comp, i_clk, i_rst_n, o_cmd.absorb && full, comp_start)
    `SHA1_ASSERT_SAME(a_out_after_pad, i_clk, i_rst_n, r_state == S_OUT, pad_done)
    `SHA1_ASSERT_NEXT(a_digest_done, i_clk, i_rst_n, digest_end, back_idle)

endmodule
`default_nettype wire

// ===== rtl/sha1_hash_engine_top.sv =====
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+------------------------------------------
// in       | input     | i_in_valid / o_in_ready | i_data_byte, i_has_byte, i_end_of_message
// out      | output    | o_out_valid/i_out_ready | o_digest_word, o_word_index, o_last_word
//
// A plain byte request is taken at once; the request that fills a block then runs
// the compression (the rounds through one shared round unit, then the fold).
// An end request pads one byte a cycle (held while a block compresses), runs one
// or two compressions, then shows the five digest words one per cycle as the output side takes them.
// Synchronous active-low reset loads the initial vector and clears the counts.
// Input is refused while a block compresses, padding runs or the digest waits.
`default_nettype none
module sha1_hash_engine_top
    import sha1_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    sha1_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_status         (dp_status),
        .o_cmd            (dp_cmd),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    sha1_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_data_byte   (i_data_byte),
        .o_status      (dp_status),
        .o_digest_word (o_digest_word)
    );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;

    localparam int          CLK_HALF     = 10;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_ITEMS = 330;
    localparam int          MIN_MESSAGES = 10;
    localparam int          STALL_HOLD   = 600;
    localparam int          DRAIN_CYCLES = 300;

    localparam logic [7:0]  MARK_BYTE  = 8'h80;
    localparam logic [5:0]  LEN_OFFSET = 6'd56;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic [159:0] DIGEST_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] DIGEST_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;
    localparam logic [159:0] DIGEST_A     = 160'h86f7e437faa5a7fce15d1ddcb9eaeaea377667b8;
    localparam logic [159:0] NO_DIGEST    = 160'h0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_has_byte = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    typedef struct packed {
        logic [7:0]   data;
        logic         has;
        logic         eom;
        logic         typed;
        logic [159:0] digest;
    } t_stim_row;

    // Directed requests; a typed digest is checked as written, the rest go
    // through the predictor.
    t_stim_row dir_rows [15] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
        '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
        '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        '{8'hff, 1'b0, 1'b1, 1'b0, NO_DIGEST},
        '{8'h55, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'haa, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'hff, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
        '{8'h61, 1'b1, 1'b1, 1'b1, DIGEST_A}
    };

    // Predictor state.
    logic [31:0] chain_h [5];
    logic [63:0] msg_bits;
    logic [7:0]  blk_bytes [64];
    logic [5:0]  blk_fill;
    logic [31:0] final_digest [5];

    t_digest_word digest_q [$];

    int fail_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_req_count = 0;

    sha1_hash_engine_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_hash();
        chain_h[0] = 32'h67452301;
        chain_h[1] = 32'hEFCDAB89;
        chain_h[2] = 32'h98BADCFE;
        chain_h[3] = 32'h10325476;
        chain_h[4] = 32'hC3D2E1F0;
        msg_bits = 64'd0;
        blk_fill = 6'd0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, sum;
        int t;
        for (t = 0; t < 16; t++)
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                wt = rotl(w[(t+13)%16] ^ w[(t+8)%16] ^ w[(t+2)%16] ^ w[t%16], 1);
                w[t%16] = wt;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            sum = rotl(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = sum;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
    endfunction

    function automatic void add_byte(input logic [7:0] v);
        blk_bytes[blk_fill] = v;
        blk_fill = blk_fill + 6'd1;
        if (blk_fill == 6'd0)
            compress_block();
    endfunction

    // Returns 1 when the request closes a message; the digest is then held
    // in final_digest and the predictor is back in its reset state.
    function automatic bit hash_request(input logic [7:0] data, input logic has,
                                        input logic eom);
        logic [63:0] len;
        int i;
        if (has) begin
            add_byte(data);
            msg_bits = msg_bits + BITS_PER_BYTE;
        end
        if (!eom)
            return 1'b0;
        len = msg_bits;
        add_byte(MARK_BYTE);
        while (blk_fill != LEN_OFFSET)
            add_byte(8'h00);
        for (i = 0; i < 8; i++)
            add_byte(len[63 - 8*i -: 8]);
        for (i = 0; i < 5; i++)
            final_digest[i] = chain_h[i];
        restart_hash();
        return 1'b1;
    endfunction

    task automatic send_request(input logic [7:0] data, input logic has, input logic eom,
                                input logic typed, input logic [159:0] known);
        t_digest_word w;
        int i;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_data_byte = data;
        i_has_byte = has;
        i_end_of_message = eom;
        do @(posedge i_clk); while (!o_in_ready);
        if (hash_request(data, has, eom)) begin
            for (i = 0; i < 5; i++) begin
                w.word = typed ? known[159 - 32*i -: 32] : final_digest[i];
                w.index = 3'(i);
                w.last = (i == 4);
                digest_q.push_back(w);
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_digest_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest word %h (index %0d)", o_digest_word, o_word_index);
                fail_count++;
            end else begin
                want = digest_q.pop_front();
                if (o_digest_word !== want.word) begin
                    $error("digest_word: expected %h, got %h", want.word, o_digest_word);
                    fail_count++;
                end
                if (o_word_index !== want.index) begin
                    $error("word_index: expected %0d, got %0d", want.index, o_word_index);
                    fail_count++;
                end
                if (o_last_word !== want.last) begin
                    $error("last_word: expected %0b, got %0b", want.last, o_last_word);
                    fail_count++;
                end
            end
        end
    end

    // Output side: random stalls, plus one long hold-off on request from the
    // stimulus so that the digest backs up and input is refused.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req_count != hold_seen) begin
                hold_seen = hold_req_count;
                hold_left = STALL_HOLD;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        int rand_items;
        int msgs;
        int len;
        int i;
        int phase;
        int last_phase;
        int pick;
        bit byte_ends;
        restart_hash();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r])
            send_request(dir_rows[r].data, dir_rows[r].has, dir_rows[r].eom,
                         dir_rows[r].typed, dir_rows[r].digest);

        rand_items = 0;
        msgs = 0;
        last_phase = 0;
        while (rand_items < RANDOM_ITEMS || msgs < MIN_MESSAGES) begin
            phase = rand_items / (RANDOM_ITEMS / 4);
            if (phase > 3)
                phase = 3;
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            if (phase == 2 && last_phase != 2)
                hold_req_count++;
            last_phase = phase;

            // The first messages sit on the block boundary, where the length
            // either still fits or spills into a second padding block.
            case (msgs)
                0: len = 55;
                1: len = 56;
                2: len = 63;
                3: len = 64;
                default: begin
                    pick = $urandom_range(99);
                    if (pick < 35)
                        len = $urandom_range(6);
                    else if (pick < 65)
                        len = $urandom_range(68, 52);
                    else if (pick < 80)
                        len = $urandom_range(130, 110);
                    else
                        len = $urandom_range(51, 7);
                end
            endcase
            byte_ends = (len > 0) && $urandom_range(1);

            for (i = 0; i < len; i++) begin
                if ($urandom_range(99) < 6)
                    send_request(8'($urandom), 1'b0, 1'b0, 1'b0, NO_DIGEST);
                send_request(8'($urandom), 1'b1, byte_ends && (i == len - 1),
                             1'b0, NO_DIGEST);
                rand_items++;
            end
            if (!byte_ends) begin
                send_request(8'($urandom), 1'b0, 1'b1, 1'b0, NO_DIGEST);
                rand_items++;
            end
            msgs++;
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        sink_stall_pct = 0;
        while (digest_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
